>>> rtl/eblm_pkg.sv
// Shared types and constants for the equalizer band level mapper.
package eblm_pkg;

  localparam int IDX_W   = 4;
  localparam int VAL_W   = 7;
  localparam int PAIR_W  = 3;
  localparam int LEVEL_W = 8;

  localparam logic [VAL_W-1:0] PERCENT_MAX   = 7'd100;
  localparam logic [VAL_W-1:0] PERCENT_UNITY = 7'd50;

  // level = ((a + b) * 2655 >> 13) - 32 + gain
  localparam logic [11:0] LEVEL_MULT  = 12'd2655;
  localparam int          LEVEL_SHIFT = 13;
  localparam logic [8:0]  LEVEL_BIAS  = 9'd32;

  // |p - 50| * 32 / 50 == (|p - 50| * 16) * 1311 >> 15 for the whole input range
  localparam logic [10:0] Q1_RECIP = 11'd1311;
  localparam int          Q1_SHIFT = 15;
  // y / 50 == y * 2622 >> 17 for y up to 3200
  localparam logic [11:0] Q2_RECIP = 12'd2622;
  localparam int          Q2_SHIFT = 17;

  // Controller to datapath strobes
  typedef struct packed {
    logic capture;   // input transfer: latch index and saturated value
    logic check;     // compare against stored slider, write on change
    logic scan;      // fold read data into running min/max
    logic gain1;     // |p-50|*32/50
    logic gain2;     // times (100-max) or min
    logic gain3;     // divide by 50, apply sign
    logic pair_a;    // latch even band of the pair
    logic pair_b;    // odd band: sum and scale
    logic load_out;  // load output register
    logic last;      // final pair of the run
  } cmd_t;

  typedef struct packed {
    logic update;    // slider value changed and index is in range
  } status_t;

endpackage

>>> rtl/eblm_datapath.sv
// Datapath: slider store, min/max scan, prefactor gain and level arithmetic.
module eblm_datapath #(
  parameter int BAND_COUNT = 10,
  parameter int CW = $clog2(BAND_COUNT)
) (
  input  logic                              clk,
  input  logic                              rst,
  input  eblm_pkg::cmd_t                    cmd,
  input  logic [CW-1:0]                     addr,
  input  logic [eblm_pkg::PAIR_W-1:0]       pair,
  input  logic [eblm_pkg::IDX_W-1:0]        in_index,
  input  logic [eblm_pkg::VAL_W-1:0]        in_value,
  output eblm_pkg::status_t                 status,
  output logic [eblm_pkg::PAIR_W-1:0]       out_pair,
  output logic signed [eblm_pkg::LEVEL_W-1:0] out_level,
  output logic                              out_last
);

  localparam int SLIDERS = BAND_COUNT + 1;

  logic [eblm_pkg::VAL_W-1:0] store [SLIDERS];
  logic [eblm_pkg::IDX_W-1:0] idx_reg;
  logic [eblm_pkg::VAL_W-1:0] val_reg;
  logic [eblm_pkg::VAL_W-1:0] rd;
  logic [4:0]                 sel;
  logic                       idx_ok;
  logic                       update;

  logic [eblm_pkg::VAL_W-1:0] lo;
  logic [eblm_pkg::VAL_W-1:0] hi;

  logic [eblm_pkg::VAL_W-1:0] p;
  logic                       p_neg;
  logic [5:0]                 dmag;
  logic [20:0]                q1_prod;
  logic [5:0]                 q1;
  logic                       neg;
  logic [eblm_pkg::VAL_W-1:0] factor;
  logic [11:0]                y;
  logic [23:0]                q2_prod;
  logic [6:0]                 g;
  logic signed [7:0]          gain;

  logic [eblm_pkg::VAL_W-1:0] a_reg;
  logic [7:0]                 pair_sum;
  logic [19:0]                prod;
  logic [6:0]                 base;
  logic signed [8:0]          level;

  // one read port, index during check, controller address otherwise
  assign sel    = cmd.check ? {1'b0, idx_reg} : 5'(addr);
  assign idx_ok = {1'b0, idx_reg} < 5'(SLIDERS);

  always_comb begin
    rd = eblm_pkg::PERCENT_UNITY;
    for (int j = 0; j < SLIDERS; j++) begin
      if (sel == 5'(j)) rd = store[j];
    end
  end

  assign update        = cmd.check && idx_ok && (rd != val_reg);
  assign status.update = update;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      idx_reg <= in_index;
      val_reg <= (in_value > eblm_pkg::PERCENT_MAX) ? eblm_pkg::PERCENT_MAX : in_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < SLIDERS; j++) store[j] <= eblm_pkg::PERCENT_UNITY;
    end else if (update) begin
      for (int j = 0; j < SLIDERS; j++) begin
        if (sel == 5'(j)) store[j] <= val_reg;
      end
    end
  end

  // running min/max over the band sliders
  always_ff @(posedge clk) begin
    if (cmd.check) begin
      lo <= '1;
      hi <= '0;
    end else if (cmd.scan) begin
      if (rd < lo) lo <= rd;
      if (rd > hi) hi <= rd;
    end
  end

  // prefactor gain, magnitudes with sign applied at the end (truncation toward zero)
  assign p       = store[BAND_COUNT];
  assign p_neg   = p < eblm_pkg::PERCENT_UNITY;
  assign dmag    = p_neg ? 6'(eblm_pkg::PERCENT_UNITY - p) : 6'(p - eblm_pkg::PERCENT_UNITY);
  assign q1_prod = {dmag, 4'b0} * eblm_pkg::Q1_RECIP;
  assign factor  = neg ? lo : eblm_pkg::PERCENT_MAX - hi;
  assign q2_prod = y * eblm_pkg::Q2_RECIP;
  assign g       = q2_prod[eblm_pkg::Q2_SHIFT +: 7];

  always_ff @(posedge clk) begin
    if (cmd.gain1) begin
      q1  <= q1_prod[eblm_pkg::Q1_SHIFT +: 6];
      neg <= p_neg;
    end
    if (cmd.gain2) y <= 12'(q1) * 12'(factor);
    if (cmd.gain3) gain <= neg ? -$signed({1'b0, g}) : $signed({1'b0, g});
  end

  // per-pair level
  assign pair_sum = {1'b0, a_reg} + {1'b0, rd};
  assign base     = prod[eblm_pkg::LEVEL_SHIFT +: 7];
  assign level    = $signed({2'b0, base}) - $signed(eblm_pkg::LEVEL_BIAS) + 9'(gain);

  always_ff @(posedge clk) begin
    if (cmd.pair_a) a_reg <= rd;
    if (cmd.pair_b) prod <= pair_sum * eblm_pkg::LEVEL_MULT;
    if (cmd.load_out) begin
      out_pair  <= pair;
      out_level <= level[eblm_pkg::LEVEL_W-1:0];
      out_last  <= cmd.last;
    end
  end

endmodule

>>> rtl/eblm_ctrl.sv
// Controller: sequences check, min/max scan, gain steps and per-pair output.
module eblm_ctrl #(
  parameter int BAND_COUNT = 10,
  parameter int CW = $clog2(BAND_COUNT)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  input  eblm_pkg::status_t           status,
  output eblm_pkg::cmd_t              cmd,
  output logic [CW-1:0]               addr,
  output logic [eblm_pkg::PAIR_W-1:0] pair
);

  localparam int PAIR_COUNT = BAND_COUNT / 2;

  typedef enum logic [9:0] {
    IDLE   = 10'b0000000001,
    CHECK  = 10'b0000000010,
    SCAN   = 10'b0000000100,
    GAIN1  = 10'b0000001000,
    GAIN2  = 10'b0000010000,
    GAIN3  = 10'b0000100000,
    PAIR_A = 10'b0001000000,
    PAIR_B = 10'b0010000000,
    PAIR_C = 10'b0100000000,
    SEND   = 10'b1000000000
  } state_t;

  state_t                      state, state_next;
  logic [CW-1:0]               cnt, cnt_next;
  logic [eblm_pkg::PAIR_W-1:0] pk, pk_next;

  assign s_tready = (state == IDLE);
  assign m_tvalid = (state == SEND);
  assign addr     = cnt;
  assign pair     = pk;

  always_comb begin
    state_next   = state;
    cnt_next     = cnt;
    pk_next      = pk;
    cmd          = '0;
    cmd.last     = (pk == eblm_pkg::PAIR_W'(PAIR_COUNT - 1));
    case (state)
      IDLE: begin
        cmd.capture = s_tvalid;
        if (s_tvalid) state_next = CHECK;
      end
      CHECK: begin
        cmd.check = 1'b1;
        cnt_next  = '0;
        state_next = status.update ? SCAN : IDLE;
      end
      SCAN: begin
        cmd.scan = 1'b1;
        if (cnt == CW'(BAND_COUNT - 1)) begin
          state_next = GAIN1;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      GAIN1: begin
        cmd.gain1  = 1'b1;
        state_next = GAIN2;
      end
      GAIN2: begin
        cmd.gain2  = 1'b1;
        state_next = GAIN3;
      end
      GAIN3: begin
        cmd.gain3  = 1'b1;
        cnt_next   = '0;
        pk_next    = '0;
        state_next = PAIR_A;
      end
      PAIR_A: begin
        cmd.pair_a = 1'b1;
        cnt_next   = cnt + 1'b1;
        state_next = PAIR_B;
      end
      PAIR_B: begin
        cmd.pair_b = 1'b1;
        cnt_next   = cnt + 1'b1;
        state_next = PAIR_C;
      end
      PAIR_C: begin
        cmd.load_out = 1'b1;
        state_next   = SEND;
      end
      SEND: begin
        if (m_tready) begin
          if (cmd.last) begin
            state_next = IDLE;
          end else begin
            pk_next    = pk + 1'b1;
            state_next = PAIR_A;
          end
        end
      end
      default: state_next = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      cnt   <= '0;
      pk    <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      pk    <= pk_next;
    end
  end

endmodule

>>> rtl/equalizer_band_level_mapper.sv
// One slider transfer at a time: a changed slider runs CHECK, a min/max SCAN of the band sliders,
// GAIN1, GAIN2, GAIN3 and then PAIR_A, PAIR_B, PAIR_C and SEND for each pair, with SEND waiting on
// m_tready; an ignored or unchanged one goes from CHECK back to IDLE. Levels go out one pair at a
// time, paced by the single store read port walked by the controller.
// Reset (rst, synchronous, active high): all sliders return to 50, controller goes idle.
// Top level of the equalizer band level mapper.
module equalizer_band_level_mapper #(
  parameter int BAND_COUNT = 10
) (
  input  logic        clk,
  input  logic        rst,
  // slider write stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [3:0] slider_index, [10:4] slider_value, [15:11] zero
  // band level stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [2:0] band_pair, [10:3] level (signed), [15:11] zero
  output logic        m_tlast    // set on the final pair of the run
);

  localparam int CW         = $clog2(BAND_COUNT);
  localparam int PAIR_COUNT = BAND_COUNT / 2;

  eblm_pkg::cmd_t                         cmd;
  eblm_pkg::status_t                      status;
  logic [CW-1:0]                          addr;
  logic [eblm_pkg::PAIR_W-1:0]            pair;
  logic [eblm_pkg::PAIR_W-1:0]            out_pair;
  logic signed [eblm_pkg::LEVEL_W-1:0]    out_level;

  // Controller owns the handshake and the band/pair counters.
  eblm_ctrl #(
    .BAND_COUNT (BAND_COUNT),
    .CW         (CW)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd),
    .addr     (addr),
    .pair     (pair)
  );

  // Datapath holds the slider store and the output register.
  eblm_datapath #(
    .BAND_COUNT (BAND_COUNT),
    .CW         (CW)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .addr      (addr),
    .pair      (pair),
    .in_index  (s_tdata[3:0]),
    .in_value  (s_tdata[10:4]),
    .status    (status),
    .out_pair  (out_pair),
    .out_level (out_level),
    .out_last  (m_tlast)
  );

  assign m_tdata = {5'b0, out_level, out_pair};

`ifndef SYNTH
  // input and output sides are never open at once
  a_excl: assert property (@(posedge clk) disable iff (rst) !(s_tready && m_tvalid))
    else $error("input ready while a result is pending");

  // after the final level of a run goes out, the block is ready again
  a_ready_after_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && m_tlast) |=> s_tready)
    else $error("not ready after final transfer");

  a_level_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($signed(m_tdata[10:3]) >= -96 && $signed(m_tdata[10:3]) <= 96))
    else $error("level out of range");

  a_pair_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[2:0] <= 3'(PAIR_COUNT - 1)))
    else $error("band pair out of range");

  a_last_pair: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast) |-> (m_tdata[2:0] == 3'(PAIR_COUNT - 1)))
    else $error("last flag on wrong pair");
`endif

endmodule
